[sv/gsem_pkg.sv]
// Package for the Sobel edge magnitude core: types, constants and helpers.
// No dependencies.
package gsem_pkg;

  localparam int unsigned MAX_LINE_PIXELS = 2048;
  localparam int unsigned LINE_AW = $clog2(MAX_LINE_PIXELS);
  localparam int unsigned STORE_AW = LINE_AW + 2;
  localparam int unsigned COL_W = LINE_AW + 1;
  localparam int unsigned ROW_W = 16;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = 2;

  localparam logic [11:0] WIDTH_RESET = 12'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  // Work for the back end: one word per accepted item, bar drain words sent during the pixel rows.
  typedef struct packed {
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic [15:0]         wr_data;
    logic                res_en;
    logic [1:0]          orow_mod;
    logic [LINE_AW-1:0]  ocol;
    logic                has_up;
    logic                has_dn;
    logic                has_lf;
    logic                has_rt;
    logic                last;
  } gsem_job_t;

  function automatic logic [7:0] luma(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    logic [31:0] s;
    s = 32'd19595 * {24'd0, r} + 32'd38470 * {24'd0, g} + 32'd7471 * {24'd0, b};
    return s[23:16];
  endfunction

endpackage

[sv/gsem_if.sv]
// Valid/ready stream interfaces for the Sobel edge magnitude core.
// No dependencies.
interface gsem_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha_in;
  modport source (output valid, cmd, red, green, blue, alpha_in, input ready);
  modport sink (input valid, cmd, red, green, blue, alpha_in, output ready);
endinterface

interface gsem_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_magnitude;
  logic [7:0] alpha_out;
  logic       frame_last;
  modport source (output valid, edge_magnitude, alpha_out, frame_last, input ready);
  modport sink (input valid, edge_magnitude, alpha_out, frame_last, output ready);
endinterface

interface gsem_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/gsem_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gsem_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

[sv/gsem_front.sv]
// Front end: raster counters, luma conversion and job issue.
// Depends on gsem_pkg.
module gsem_front import gsem_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  gsem_in_if.sink      in_ch,
  gsem_cfg_if.sink     cfg_ch,
  input  logic         q_full,
  output logic         q_push,
  output gsem_job_t    q_job
);
  logic [11:0]      width_r;
  logic [15:0]      height_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W:0]   row_r;
  logic [COL_W-1:0] ocol_r;
  logic [ROW_W-1:0] orow_r;
  logic             started_r;

  logic [COL_W-1:0] w;
  logic [ROW_W-1:0] h;
  logic             pix_phase, ignore, writes, emits, frame_end;
  logic [COL_W-1:0] col_inc;
  logic [ROW_W:0]   row_inc;
  logic             ocol_end, orow_end;

  always_comb begin
    if (width_r == 12'd0) w = COL_W'(1);
    else if ({1'b0, width_r} > 13'(MAX_LINE_PIXELS)) w = COL_W'(MAX_LINE_PIXELS);
    else w = COL_W'(width_r);
    h = (height_r == 16'd0) ? 16'd1 : height_r;
  end

  // The output position trails the input by one row plus one pixel.
  assign pix_phase = row_r < {1'b0, h};
  assign ignore    = (in_ch.cmd == CMD_DRAIN) && pix_phase;
  assign writes    = pix_phase && (col_r < w);
  assign emits     = started_r && (orow_r < h) && (ocol_r < w);
  assign ocol_end  = (ocol_r + COL_W'(1)) >= w;
  assign orow_end  = ({1'b0, orow_r} + 17'd1) >= {1'b0, h};
  assign frame_end = (emits && ocol_end && orow_end) || (started_r && !emits);
  assign col_inc   = col_r + COL_W'(1);
  assign row_inc   = row_r + (ROW_W+1)'(1);

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;

  assign q_push = in_ch.valid && !q_full && !ignore;
  always_comb begin
    q_job.wr_en    = writes;
    q_job.wr_addr  = {row_r[1:0], col_r[LINE_AW-1:0]};
    q_job.wr_data  = {luma(in_ch.red, in_ch.green, in_ch.blue), in_ch.alpha_in};
    q_job.res_en   = emits;
    q_job.orow_mod = orow_r[1:0];
    q_job.ocol     = ocol_r[LINE_AW-1:0];
    q_job.has_up   = orow_r != '0;
    q_job.has_dn   = !orow_end;
    q_job.has_lf   = ocol_r != '0;
    q_job.has_rt   = !ocol_end;
    q_job.last     = ocol_end && orow_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WIDTH_RESET;
      height_r  <= HEIGHT_RESET;
      col_r     <= '0;
      row_r     <= '0;
      ocol_r    <= '0;
      orow_r    <= '0;
      started_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_FRAME_WIDTH:  width_r <= cfg_ch.data[11:0];
          REG_FRAME_HEIGHT: height_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (q_push) begin
        if (frame_end) begin
          col_r     <= '0;
          row_r     <= '0;
          ocol_r    <= '0;
          orow_r    <= '0;
          started_r <= 1'b0;
        end else begin
          if (col_inc >= w) begin
            col_r <= '0;
            row_r <= row_inc;
          end else begin
            col_r <= col_inc;
          end
          if (row_r == (ROW_W+1)'(1) && col_r == '0) started_r <= 1'b1;
          if (started_r) begin
            if (ocol_end) begin
              ocol_r <= '0;
              orow_r <= orow_r + ROW_W'(1);
            end else begin
              ocol_r <= ocol_r + COL_W'(1);
            end
          end
        end
      end
    end
  end
endmodule

[sv/gsem_queue.sv]
// Short job queue between the front and back ends.
// Depends on gsem_pkg.
module gsem_queue import gsem_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  gsem_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output gsem_job_t head
);
  gsem_job_t         slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_r, rp_r;
  logic [QUEUE_AW:0]   cnt_r;

  assign full  = cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QUEUE_AW'(1);
      if (pop) rp_r <= rp_r + QUEUE_AW'(1);
      cnt_r <= cnt_r + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
    else $error("queue underflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + (QUEUE_AW+1)'(1))
    else $error("queue count lost a push");
endmodule

[sv/gsem_back.sv]
// Back end: line store writes, nine-tap window fetch, Sobel sums and root.
// Depends on gsem_pkg and gsem_ram.
module gsem_back import gsem_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  gsem_job_t  q_head,
  output logic       q_pop,
  gsem_out_if.source out_ch
);
  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_CALC, S_ROOT, S_SEND
  } state_t;

  state_t          state_r;
  gsem_job_t       job_r;
  logic [3:0]      tap_r;
  logic [7:0]      win_r [9];
  logic [7:0]      alpha_r;
  logic signed [11:0] gx_r, gy_r;
  logic [17:0]     rem_r;
  logic [17:0]     root_r;
  logic [17:0]     bit_r;
  logic            sat_r;
  logic [7:0]      mag_r;
  logic            last_r;
  logic            rd_pend_r;
  logic [3:0]      rd_tap_r;
  logic            rd_ok_r;

  logic                rd_ok;
  logic [1:0]          rrow;
  logic [LINE_AW-1:0]  rcol;
  logic [15:0]         rd_data;
  logic                ram_we;
  logic [STORE_AW-1:0] ram_wa;
  logic [15:0]         ram_wd;
  logic [17:0]         trial;
  logic [21:0]         sq_sum;

  // Tap order: dr*3+dc over the 3x3 window.
  always_comb begin
    rrow = job_r.orow_mod;
    rcol = job_r.ocol;
    rd_ok = 1'b1;
    case (tap_r)
      4'd0, 4'd1, 4'd2: begin rrow = job_r.orow_mod - 2'd1; rd_ok = job_r.has_up; end
      4'd6, 4'd7, 4'd8: begin rrow = job_r.orow_mod + 2'd1; rd_ok = job_r.has_dn; end
      default: ;
    endcase
    case (tap_r)
      4'd0, 4'd3, 4'd6: begin
        rcol = job_r.ocol - LINE_AW'(1);
        rd_ok = rd_ok && job_r.has_lf;
      end
      4'd2, 4'd5, 4'd8: begin
        rcol = job_r.ocol + LINE_AW'(1);
        rd_ok = rd_ok && job_r.has_rt;
      end
      default: ;
    endcase
  end

  assign ram_we = (state_r == S_IDLE) && !q_empty && q_head.wr_en;
  assign ram_wa = q_head.wr_addr;
  assign ram_wd = q_head.wr_data;
  assign q_pop  = (state_r == S_IDLE) && !q_empty;

  gsem_ram #(.WIDTH(16), .DEPTH(1 << STORE_AW)) u_ram (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
    .rd_addr({rrow, rcol}), .rd_data(rd_data)
  );

  assign trial  = rem_r - (root_r + bit_r);
  assign sq_sum = 22'(gx_r * gx_r) + 22'(gy_r * gy_r);

  assign out_ch.valid          = state_r == S_SEND;
  assign out_ch.edge_magnitude = mag_r;
  assign out_ch.alpha_out      = alpha_r;
  assign out_ch.frame_last     = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_pend_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (!q_empty && q_head.res_en) begin
            job_r   <= q_head;
            tap_r   <= '0;
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          rd_pend_r <= tap_r != 4'd9;
          rd_tap_r  <= tap_r;
          rd_ok_r   <= rd_ok;
          if (rd_pend_r) begin
            win_r[rd_tap_r] <= rd_ok_r ? rd_data[15:8] : 8'd0;
            if (rd_tap_r == 4'd4) alpha_r <= rd_data[7:0];
          end
          if (tap_r == 4'd9) begin
            state_r <= S_CALC;
          end else begin
            tap_r <= tap_r + 4'd1;
          end
        end
        S_CALC: begin
          rd_pend_r <= 1'b0;
          gx_r <= 12'(signed'({4'd0, win_r[0]})) + 12'(signed'({3'd0, win_r[3], 1'b0}))
                + 12'(signed'({4'd0, win_r[6]})) - 12'(signed'({4'd0, win_r[2]}))
                - 12'(signed'({3'd0, win_r[5], 1'b0})) - 12'(signed'({4'd0, win_r[8]}));
          gy_r <= 12'(signed'({4'd0, win_r[0]})) + 12'(signed'({3'd0, win_r[1], 1'b0}))
                + 12'(signed'({4'd0, win_r[2]})) - 12'(signed'({4'd0, win_r[6]}))
                - 12'(signed'({3'd0, win_r[7], 1'b0})) - 12'(signed'({4'd0, win_r[8]}));
          root_r  <= '0;
          bit_r   <= 18'h10000;
          last_r  <= job_r.last;
          state_r <= S_ROOT;
          tap_r   <= '0;
        end
        S_ROOT: begin
          if (tap_r == 4'd0) begin
            rem_r <= sq_sum[17:0];
            sat_r <= sq_sum[21:16] != '0;
            tap_r <= 4'd1;
          end else if (bit_r == '0) begin
            mag_r   <= (sat_r || root_r > 18'd255) ? 8'd255 : root_r[7:0];
            state_r <= S_SEND;
          end else begin
            if (rem_r >= root_r + bit_r) begin
              rem_r  <= trial;
              root_r <= (root_r >> 1) + bit_r;
            end else begin
              root_r <= root_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end
        end
        S_SEND: if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(out_ch.edge_magnitude))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> state_r == S_IDLE)
    else $error("job taken while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEND) |-> !ram_we)
    else $error("store written during send");
endmodule

[sv/grayscale_sobel_edge_magnitude_core.sv]
// Sobel 3x3 edge magnitude over RGBA raster frames. Each accepted pixel is
// converted to grey and written into a four-row line store; results trail the
// input by one row plus one pixel, and frame_width+1 drain words after each
// frame flush the rest. An item that only writes is done once the back end
// takes it from the queue; an item that yields a result passes these steps:
// take the job and write the store, read the nine taps through the single
// registered store read port, form the Sobel sums, load the bit-serial root,
// run its nine steps and clamp, and send the result.
module grayscale_sobel_edge_magnitude_core import gsem_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  gsem_in_if.sink      in_ch,
  gsem_out_if.source   out_ch,
  gsem_cfg_if.sink     cfg_ch
);
  logic      q_push, q_full, q_pop, q_empty;
  gsem_job_t q_job, q_head;

  gsem_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cfg_ch(cfg_ch),
    .q_full(q_full), .q_push(q_push), .q_job(q_job)
  );

  gsem_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_job(q_job), .full(q_full),
    .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  gsem_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
    .out_ch(out_ch)
  );
endmodule
